// ===== rtl/aarq_pkg.sv =====
// Package for the association request element locator.
// Holds the item types, the kind and status codes and the tag decoder.
// Used by aarq_parser, aarq_emitter and aarq_tlv_element_locator.
package aarq_pkg;

  localparam int unsigned KindCount = 11;
  localparam int unsigned KindW     = 4;
  localparam int unsigned OffW      = 9;
  localparam int unsigned LenW      = 8;
  localparam int unsigned TagPosW   = 10;

  localparam logic [KindW-1:0]   KindNone   = 4'd11;
  localparam logic [OffW-1:0]    PosMax     = 9'd511;
  localparam logic [TagPosW-1:0] FirstTagPos = 10'd2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_UNKNOWN  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_STOP = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0] entry_kind;
    logic [OffW-1:0]  entry_offset;
    logic [LenW-1:0]  entry_length;
    logic             has_entry;
    logic [1:0]       frame_status;
    logic             last_result;
  } out_item_t;

  // Frame summary handed from the parser to the emitter at the last byte.
  typedef struct packed {
    logic                               valid;
    logic                               single;
    status_e                            status;
    logic [KindCount-1:0]               mask;
    logic [KindCount-1:0][OffW-1:0]     offs;
    logic [KindCount-1:0][LenW-1:0]     lens;
  } snap_t;

  function automatic logic [KindW-1:0] tag_kind(input logic [7:0] tag);
    logic [KindW-1:0] k;
    begin
      unique case (tag)
        8'h80:        k = 4'd0;
        8'hA1:        k = 4'd1;
        8'hA6:        k = 4'd2;
        8'hA7:        k = 4'd3;
        8'hA8:        k = 4'd4;
        8'hA9:        k = 4'd5;
        8'h8A:        k = 4'd6;
        8'h8B:        k = 4'd7;
        8'h9D, 8'hBD: k = 4'd8;
        8'hAC:        k = 4'd9;
        8'hBE:        k = 4'd10;
        default:      k = KindNone;
      endcase
      return k;
    end
  endfunction

endpackage

// ===== rtl/aarq_parser.sv =====
// Byte-level element parser: tracks position, phase and the recorded tables.
// Produces a frame summary when the last byte is accepted.
// Depends on aarq_pkg.
module aarq_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  aarq_pkg::in_item_t item_i,
  output aarq_pkg::snap_t    snap_o
);

  logic [aarq_pkg::OffW-1:0]    pos_q, pos_d;
  logic [7:0]                   decl_q, decl_d;
  logic [aarq_pkg::TagPosW-1:0] ntp_q, ntp_d;
  aarq_pkg::phase_e             phase_q, phase_d;
  logic [aarq_pkg::KindW-1:0]   pend_q, pend_d;
  logic [aarq_pkg::KindCount-1:0] mask_q, mask_d;
  logic                         unk_q, unk_d;

  logic [aarq_pkg::OffW-1:0] offs_q [aarq_pkg::KindCount];
  logic [aarq_pkg::LenW-1:0] lens_q [aarq_pkg::KindCount];

  logic                       wr_en;
  logic [aarq_pkg::KindW-1:0] wr_kind;
  logic [aarq_pkg::KindW-1:0] tag_k;
  logic                       mismatch;

  assign tag_k = aarq_pkg::tag_kind(item_i.data_byte);

  always_comb begin
    decl_d  = decl_q;
    ntp_d   = ntp_q;
    phase_d = phase_q;
    pend_d  = pend_q;
    mask_d  = mask_q;
    unk_d   = unk_q;
    wr_en   = 1'b0;
    wr_kind = pend_q;
    if (pos_q == 9'd1) begin
      decl_d = item_i.data_byte;
    end else if (pos_q >= 9'd2) begin
      if (phase_q == aarq_pkg::PH_LEN) begin
        wr_en   = 1'b1;
        mask_d  = mask_q | (11'd1 << pend_q);
        ntp_d   = ntp_q + {2'b00, item_i.data_byte} + 10'd2;
        phase_d = aarq_pkg::PH_TAG;
      end else if (phase_q == aarq_pkg::PH_TAG && {1'b0, pos_q} == ntp_q) begin
        if (tag_k != aarq_pkg::KindNone) begin
          pend_d  = tag_k;
          phase_d = aarq_pkg::PH_LEN;
        end else begin
          unk_d   = 1'b1;
          phase_d = aarq_pkg::PH_STOP;
        end
      end
    end
    pos_d = (pos_q == aarq_pkg::PosMax) ? pos_q : pos_q + 9'd1;
  end

  assign mismatch = ({1'b0, pos_q} + 10'd1) != ({2'b00, decl_d} + 10'd2);

  always_comb begin
    snap_o.valid  = accept_i & item_i.last_byte;
    snap_o.single = mismatch | (mask_d == '0);
    snap_o.mask   = mismatch ? '0 : mask_d;
    if (mismatch) begin
      snap_o.status = aarq_pkg::STATUS_MISMATCH;
    end else if (unk_d) begin
      snap_o.status = aarq_pkg::STATUS_UNKNOWN;
    end else begin
      snap_o.status = aarq_pkg::STATUS_OK;
    end
    for (int k = 0; k < aarq_pkg::KindCount; k++) begin
      if (wr_en && wr_kind == 4'(k)) begin
        snap_o.offs[k] = ntp_q[aarq_pkg::OffW-1:0];
        snap_o.lens[k] = item_i.data_byte;
      end else begin
        snap_o.offs[k] = offs_q[k];
        snap_o.lens[k] = lens_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      decl_q  <= '0;
      ntp_q   <= aarq_pkg::FirstTagPos;
      phase_q <= aarq_pkg::PH_TAG;
      pend_q  <= '0;
      mask_q  <= '0;
      unk_q   <= 1'b0;
    end else if (accept_i) begin
      if (item_i.last_byte) begin
        pos_q   <= '0;
        decl_q  <= '0;
        ntp_q   <= aarq_pkg::FirstTagPos;
        phase_q <= aarq_pkg::PH_TAG;
        pend_q  <= '0;
        mask_q  <= '0;
        unk_q   <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        decl_q  <= decl_d;
        ntp_q   <= ntp_d;
        phase_q <= phase_d;
        pend_q  <= pend_d;
        mask_q  <= mask_d;
        unk_q   <= unk_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) begin
      offs_q[wr_kind] <= ntp_q[aarq_pkg::OffW-1:0];
      lens_q[wr_kind] <= item_i.data_byte;
    end
  end

`ifndef SYNTH
  a_stop_has_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == aarq_pkg::PH_STOP) |-> unk_q)
    else $error("Parsing stopped without an unknown tag.");

  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (phase_q == aarq_pkg::PH_TAG && mask_q == '0 && !unk_q))
    else $error("Frame state not clear at frame start.");

  a_len_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == aarq_pkg::PH_LEN) |-> (pend_q < aarq_pkg::KindNone))
    else $error("Length phase with an unknown pending kind.");
`endif

endmodule

// ===== rtl/aarq_emitter.sv =====
// Result emitter: holds one frame summary and sends one result item per cycle
// unless stalled. Output register with stall on the result channel.
// Depends on aarq_pkg.
module aarq_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aarq_pkg::snap_t     snap_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aarq_pkg::out_item_t out_item_o
);

  logic                             busy_q, busy_d;
  logic                             single_q;
  aarq_pkg::status_e                status_q;
  logic [aarq_pkg::KindCount-1:0]   mask_q, mask_d;
  logic [aarq_pkg::OffW-1:0]        offs_q [aarq_pkg::KindCount];
  logic [aarq_pkg::LenW-1:0]        lens_q [aarq_pkg::KindCount];

  logic                out_valid_q;
  aarq_pkg::out_item_t out_item_q, out_item_d;

  logic                       load;
  logic [aarq_pkg::KindW-1:0] sel;
  logic [aarq_pkg::KindCount-1:0] rest;

  assign load = busy_q & (~out_valid_q | ~out_stall_i);

  always_comb begin
    sel = '0;
    for (int k = aarq_pkg::KindCount - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        sel = 4'(k);
      end
    end
    rest = mask_q & ~(11'd1 << sel);
  end

  always_comb begin
    busy_d = busy_q;
    mask_d = mask_q;
    out_item_d.frame_status = status_q;
    if (single_q) begin
      out_item_d.entry_kind   = '0;
      out_item_d.entry_offset = '0;
      out_item_d.entry_length = '0;
      out_item_d.has_entry    = 1'b0;
      out_item_d.last_result  = 1'b1;
    end else begin
      out_item_d.entry_kind   = sel;
      out_item_d.entry_offset = offs_q[sel];
      out_item_d.entry_length = lens_q[sel];
      out_item_d.has_entry    = 1'b1;
      out_item_d.last_result  = (rest == '0);
    end
    if (load) begin
      mask_d = single_q ? '0 : rest;
      busy_d = ~single_q & (rest != '0);
    end
    if (snap_i.valid) begin
      busy_d = 1'b1;
      mask_d = snap_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      mask_q      <= '0;
      single_q    <= 1'b0;
      status_q    <= aarq_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      mask_q <= mask_d;
      if (snap_i.valid) begin
        single_q <= snap_i.single;
        status_q <= snap_i.status;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_i.valid) begin
      for (int k = 0; k < aarq_pkg::KindCount; k++) begin
        offs_q[k] <= snap_i.offs[k];
        lens_q[k] <= snap_i.lens[k];
      end
    end
    if (load) begin
      out_item_q <= out_item_d;
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_snap_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_i.valid |-> !busy_q)
    else $error("Frame summary arrived while results were pending.");

  a_idle_mask_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (mask_q == '0))
    else $error("Entries left over after emission finished.");

  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.has_entry) |-> out_item_q.last_result)
    else $error("Status-only result not marked last.");

  a_last_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_item_d.last_result && !snap_i.valid) |=> !busy_q)
    else $error("Emitter still busy after the last result.");
`endif

endmodule

// ===== rtl/aarq_tlv_element_locator.sv =====
// Top level of the association request element locator.
// Instantiates aarq_parser and aarq_emitter; depends on aarq_pkg.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_item_i) carries one frame
//   byte per item with a flag on the final byte. The result channel
//   (out_valid_o, out_stall_i, out_item_o) carries one result per item.
//   An item moves at a clock edge where valid is high and stall is low.
//   Bytes are taken one per cycle except when a last byte is held off, so
//   frames stream at one byte per cycle. The last byte of a frame copies
//   the recorded elements into the emitter, which then loads its results
//   to the output register one per unstalled cycle, up to eleven per frame.
//   Bytes of the next frame are accepted while results are still going
//   out; only a last byte is held off until the emitter has handed its
//   final result to the output register.
//   When the receiver stalls, the output register holds its result and the
//   emitter waits behind it.
//   Reset clears the frame position, phase, masks, busy and output valid
//   flags; the element tables hold no defined value until written.
module aarq_tlv_element_locator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aarq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aarq_pkg::out_item_t out_item_o
);

  logic            busy;
  logic            accept;
  aarq_pkg::snap_t snap;

  assign in_stall_o = busy & in_valid_i & in_item_i.last_byte;
  assign accept     = in_valid_i & ~in_stall_o;

  aarq_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .snap_o   (snap)
  );

  aarq_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (snap),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTH
  a_no_summary_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_item_i.last_byte && busy) |-> !snap.valid)
    else $error("Frame summary produced for a held last byte.");

  a_summary_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap.valid |-> (accept && in_item_i.last_byte))
    else $error("Frame summary without an accepted last byte.");

  a_summary_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap.valid |=> busy)
    else $error("Emitter did not take the frame summary.");
`endif

endmodule
